// ===== rtl/hvn_pkg.sv =====
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared widths, hash constants and pipeline depth for the 3D value noise
// ----------------------------------------------------------------------------
package hvn_pkg;

    localparam int COORD_W   = 32;
    localparam int HASH_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int NOISE_W   = 24;
    localparam int AXES      = 3;
    localparam int CORNERS   = 8;

    // total register stages from the input register to the result register
    localparam int PIPE_DEPTH = 15;

    localparam logic [HASH_W-1:0] PRIME_X = 32'd73856093;
    localparam logic [HASH_W-1:0] PRIME_Y = 32'd19349663;
    localparam logic [HASH_W-1:0] PRIME_Z = 32'd83492791;
    localparam logic [HASH_W-1:0] MIX_C1  = 32'h7feb352d;
    localparam logic [HASH_W-1:0] MIX_C2  = 32'h846ca68b;

    // 3.0 in Q2.16, the constant term of the smoothstep
    localparam logic [FRAC_W+1:0] SMOOTH_THREE = 18'd196608;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    function automatic logic [HASH_W-1:0] axis_prime(input axis_t axis);
        logic [HASH_W-1:0] p;
        unique case (axis)
            AXIS_X:  p = PRIME_X;
            AXIS_Y:  p = PRIME_Y;
            AXIS_Z:  p = PRIME_Z;
            default: p = PRIME_X;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/hashed_value_noise_3d.sv =====
// ----------------------------------------------------------------------------
// hashed_value_noise_3d
// 3D value noise: hashed lattice corners blended trilinearly with smoothstep
// ----------------------------------------------------------------------------
// throughput: one item per cycle; busy is never raised, the pipeline never stalls
// the depth is set by the hash mixer (two multiplies) and three chained lerps
// reset clears only the valid bits; payload registers are left as they are
module hashed_value_noise_3d
    import hvn_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    output logic                      done,
    output logic [NOISE_W-1:0]        noise_value
);

    logic [PIPE_DEPTH-1:0]             vld_reg;
    logic [AXES-1:0][COORD_W-1:0]      pt_reg;
    logic [AXES-1:0][HASH_W-1:0]       lat_cell;
    logic [AXES-1:0][FRAC_W-1:0]       frac;
    logic [AXES-1:0][HASH_W-1:0]       mul_reg;
    logic [AXES-1:0][FRAC_W-1:0]       frac_reg;
    logic [AXES-1:0][HASH_W-1:0]       mul_next;
    logic [AXES-1:0][FRAC_W-1:0]       s_raw;
    logic [AXES-1:0][FRAC_W-1:0]       s_al;
    logic [CORNERS-1:0][HASH_W-1:0]    seed;
    logic [CORNERS-1:0][NOISE_W-1:0]   cv;
    logic [3:0][NOISE_W-1:0]           lx;
    logic [1:0][NOISE_W-1:0]           ly;
    logic [NOISE_W-1:0]                lz;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], start & ~busy};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            pt_reg <= {point_z, point_y, point_x};
        end
        mul_reg  <= mul_next;
        frac_reg <= frac;
    end

    for (genvar a = 0; a < AXES; a++)
    begin : g_axis
        localparam int DLY = 2 + 3 * a;
        logic [DLY-1:0][FRAC_W-1:0] sd_reg;

        assign lat_cell[a] = HASH_W'($signed(pt_reg[a]) >>> COORD_FRAC_BITS);
        assign mul_next[a] = lat_cell[a] * axis_prime(axis_t'(a));

        if (COORD_FRAC_BITS >= FRAC_W)
        begin : g_frac_trunc
            assign frac[a] = pt_reg[a][COORD_FRAC_BITS-1 -: FRAC_W];
        end
        else
        begin : g_frac_pad
            assign frac[a] = {pt_reg[a][COORD_FRAC_BITS-1:0],
                              {(FRAC_W-COORD_FRAC_BITS){1'b0}}};
        end

        hvn_smooth u_smooth (
            .clk    (clk),
            .frac   (frac_reg[a]),
            .weight (s_raw[a])
        );

        // line the weight up with the lerp level that uses it
        always_ff @(posedge clk)
        begin
            sd_reg <= {sd_reg[DLY-2:0], s_raw[a]};
        end
        assign s_al[a] = sd_reg[DLY-1];
    end

    // corner c: bit 0 picks x+1, bit 1 y+1, bit 2 z+1; (c+1)*p = c*p + p
    for (genvar c = 0; c < CORNERS; c++)
    begin : g_corner
        logic [AXES-1:0][HASH_W-1:0] term;

        for (genvar a = 0; a < AXES; a++)
        begin : g_term
            assign term[a] = ((c >> a) & 1) != 0
                           ? mul_reg[a] + axis_prime(axis_t'(a))
                           : mul_reg[a];
        end

        assign seed[c] = term[0] ^ term[1] ^ term[2];

        hvn_hash u_hash (
            .clk          (clk),
            .seed         (seed[c]),
            .corner_value (cv[c])
        );
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_lerp_x
        hvn_lerp u_lerp (
            .clk (clk),
            .a   (cv[2*k]),
            .b   (cv[2*k+1]),
            .s   (s_al[AXIS_X]),
            .y   (lx[k])
        );
    end

    for (genvar m = 0; m < 2; m++)
    begin : g_lerp_y
        hvn_lerp u_lerp (
            .clk (clk),
            .a   (lx[2*m]),
            .b   (lx[2*m+1]),
            .s   (s_al[AXIS_Y]),
            .y   (ly[m])
        );
    end

    hvn_lerp u_lerp_z (
        .clk (clk),
        .a   (ly[0]),
        .b   (ly[1]),
        .s   (s_al[AXIS_Z]),
        .y   (lz)
    );

    assign done        = vld_reg[PIPE_DEPTH-1];
    assign noise_value = lz;

`ifndef SYNTHESIS
    a_item_emerges: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_DEPTH done)
        else $error("accepted item did not produce a result");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_DEPTH))
        else $error("result without a matching accepted item");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> vld_reg[0])
        else $error("valid line lost an accepted item");
`endif

endmodule

// ===== rtl/hvn_hash.sv =====
// ----------------------------------------------------------------------------
// hvn_hash
// Four-stage shift, multiply and xor mixer giving a 24-bit corner value
// ----------------------------------------------------------------------------
module hvn_hash
    import hvn_pkg::*;
(
    input  logic               clk,
    input  logic [HASH_W-1:0]  seed,
    output logic [NOISE_W-1:0] corner_value
);

    logic [HASH_W-1:0]  r0_reg;
    logic [HASH_W-1:0]  r1_reg;
    logic [HASH_W-1:0]  r2_reg;
    logic [NOISE_W-1:0] val_reg;
    logic [HASH_W-1:0]  r1_mix;
    logic [HASH_W-1:0]  r2_mix;

    assign r1_mix = r1_reg ^ (r1_reg >> 15);
    assign r2_mix = r2_reg ^ (r2_reg >> 16);

    always_ff @(posedge clk)
    begin
        r0_reg  <= seed ^ (seed >> 16);
        r1_reg  <= r0_reg * MIX_C1;
        r2_reg  <= r1_mix * MIX_C2;
        val_reg <= r2_mix[NOISE_W-1:0];
    end

    assign corner_value = val_reg;

endmodule

// ===== rtl/hvn_smooth.sv =====
// ----------------------------------------------------------------------------
// hvn_smooth
// Two-stage smoothstep of a Q0.16 fraction, truncated once at the end
// ----------------------------------------------------------------------------
module hvn_smooth
    import hvn_pkg::*;
(
    input  logic              clk,
    input  logic [FRAC_W-1:0] frac,
    output logic [FRAC_W-1:0] weight
);

    logic [2*FRAC_W-1:0]         ff_reg;
    logic [FRAC_W-1:0]           f_d_reg;
    logic [FRAC_W-1:0]           s_reg;
    logic [FRAC_W+1:0]           t;
    logic [2*FRAC_W+FRAC_W+1:0]  prod;

    // t = 3 - 2f in Q2.16
    assign t    = SMOOTH_THREE - {1'b0, f_d_reg, 1'b0};
    assign prod = {{(FRAC_W+2){1'b0}}, ff_reg} * {{(2*FRAC_W){1'b0}}, t};

    always_ff @(posedge clk)
    begin
        ff_reg  <= {{FRAC_W{1'b0}}, frac} * {{FRAC_W{1'b0}}, frac};
        f_d_reg <= frac;
        s_reg   <= prod[2*FRAC_W+FRAC_W-1:2*FRAC_W];
    end

    assign weight = s_reg;

endmodule

// ===== rtl/hvn_lerp.sv =====
// ----------------------------------------------------------------------------
// hvn_lerp
// Three-stage linear blend a + (b - a) * s, product truncated toward zero
// ----------------------------------------------------------------------------
module hvn_lerp
    import hvn_pkg::*;
(
    input  logic               clk,
    input  logic [NOISE_W-1:0] a,
    input  logic [NOISE_W-1:0] b,
    input  logic [FRAC_W-1:0]  s,
    output logic [NOISE_W-1:0] y
);

    logic [NOISE_W-1:0]        a1_reg;
    logic [NOISE_W-1:0]        mag_reg;
    logic                      neg1_reg;
    logic [FRAC_W-1:0]         s_reg;
    logic [NOISE_W-1:0]        a2_reg;
    logic [NOISE_W-1:0]        step_reg;
    logic                      neg2_reg;
    logic [NOISE_W-1:0]        y_reg;
    logic                      neg;
    logic [NOISE_W+FRAC_W-1:0] prod;

    assign neg  = b < a;
    assign prod = {{FRAC_W{1'b0}}, mag_reg} * {{NOISE_W{1'b0}}, s_reg};

    always_ff @(posedge clk)
    begin
        a1_reg   <= a;
        mag_reg  <= neg ? (a - b) : (b - a);
        neg1_reg <= neg;
        s_reg    <= s;

        a2_reg   <= a1_reg;
        step_reg <= prod[NOISE_W+FRAC_W-1:FRAC_W];
        neg2_reg <= neg1_reg;

        // result stays between a and b, no wrap
        y_reg    <= neg2_reg ? (a2_reg - step_reg) : (a2_reg + step_reg);
    end

    assign y = y_reg;

endmodule
